FILE: hdl/rmm_pkg.sv
package rmm_pkg;

  // Operation field
  localparam int OP_BITS = 2;

  typedef logic [OP_BITS-1:0] rmm_op_t;

  localparam rmm_op_t OP_ADD   = 2'd0;
  localparam rmm_op_t OP_MERGE = 2'd1;
  localparam rmm_op_t OP_CLEAR = 2'd2;

endpackage

FILE: hdl/rmm_in_if.sv
interface rmm_in_if
  import rmm_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
);
  logic                         valid;
  logic                         ready;
  rmm_op_t                      operation;
  logic signed [VALUE_BITS-1:0] value;
  logic [COUNT_BITS-1:0]        part_count;

  modport source (output valid, output operation, output value, output part_count,
                  input ready);
  modport sink   (input valid, input operation, input value, input part_count,
                  output ready);
endinterface

FILE: hdl/rmm_out_if.sv
interface rmm_out_if #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] mean_out;
  logic [COUNT_BITS-1:0]        count_out;
  logic                         overflowed;

  modport source (output valid, output mean_out, output count_out, output overflowed,
                  input ready);
  modport sink   (input valid, input mean_out, input count_out, input overflowed,
                  output ready);
endinterface

FILE: hdl/running_mean_merge_top.sv
// Running mean with partial-aggregate merge.
// Channel req carries one request: operation (add sample, merge partial
// aggregate, clear), value (sample or partial mean) and part_count (merge
// only). Channel rsp returns exactly one result per request: the mean and
// count after the request, and overflowed when the request was dropped
// because the count would wrap.
// One request is worked on at a time; req.ready is high only when idle.
// Clear, merge of an empty or into an empty aggregate, and dropped requests
// go straight from idle to the finish state. An add runs a bit-serial
// restoring divider, then updates the mean and count. A merge first runs a
// bit-serial shift-add multiply and then the divider.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls and another result is ready, the block
// holds it until the output register frees.
// Synchronous reset clears the mean and count to zero and empties the output.
module running_mean_merge_top
  import rmm_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  rmm_in_if.sink   req,
  rmm_out_if.source rsp
);

  localparam int PROD_BITS = VALUE_BITS + 1 + COUNT_BITS;
  localparam int MAX_STEPS = (COUNT_BITS > VALUE_BITS + 1) ? COUNT_BITS : VALUE_BITS + 1;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_UPD, S_FIN} state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   mean_reg;
  logic [COUNT_BITS-1:0]   count_reg;
  logic                    ovf_reg;
  logic [VALUE_BITS:0]     mag_reg;
  logic                    neg_reg;
  logic [COUNT_BITS-1:0]   divisor;
  logic [PROD_BITS-1:0]    work;
  logic [STEP_W-1:0]       step;
  logic                    out_valid;
  logic [VALUE_BITS-1:0]   out_mean;
  logic [COUNT_BITS-1:0]   out_count;
  logic                    out_ovf;

  logic [VALUE_BITS:0]     delta;
  logic                    delta_neg;
  logic [VALUE_BITS:0]     delta_mag;
  logic [COUNT_BITS:0]     count_sum;
  logic                    count_full;
  logic [VALUE_BITS+1:0]   mul_sum;
  logic [PROD_BITS-1:0]    work_mul;
  logic [COUNT_BITS:0]     div_trial;
  logic [COUNT_BITS:0]     div_diff;
  logic                    div_ge;
  logic [PROD_BITS-1:0]    work_div;
  logic [VALUE_BITS-1:0]   quot;
  logic [VALUE_BITS-1:0]   mean_next;

  // Difference to the current mean and new count
  always_comb begin
    delta      = {req.value[VALUE_BITS-1], req.value} - {mean_reg[VALUE_BITS-1], mean_reg};
    delta_neg  = delta[VALUE_BITS];
    delta_mag  = delta_neg ? (~delta + 1'b1) : delta;
    count_sum  = {1'b0, count_reg} + {1'b0, req.part_count};
    count_full = &count_reg;
  end

  // Shift-add multiply step: high half accumulates, multiplier shifts out low
  always_comb begin
    mul_sum  = work[0] ? ({1'b0, work[PROD_BITS-1:COUNT_BITS]} + {1'b0, mag_reg})
                       : {1'b0, work[PROD_BITS-1:COUNT_BITS]};
    work_mul = {mul_sum, work[COUNT_BITS-1:1]};
  end

  // Restoring divide step: remainder on top, dividend/quotient below
  always_comb begin
    div_trial = work[PROD_BITS-1:VALUE_BITS];
    div_ge    = div_trial >= {1'b0, divisor};
    div_diff  = div_trial - {1'b0, divisor};
    work_div  = {(div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0]),
                 work[VALUE_BITS-1:0], div_ge};
  end

  // Move the mean by the truncated quotient
  always_comb begin
    quot      = work[VALUE_BITS-1:0];
    mean_next = neg_reg ? (mean_reg - quot) : (mean_reg + quot);
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.mean_out   = out_mean;
  assign rsp.count_out  = out_count;
  assign rsp.overflowed = out_ovf;

  // Sequencer, state registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mean_reg  <= '0;
      count_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output register empties on a taken result unless refilled below
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mag_reg <= delta_mag;
            neg_reg <= delta_neg;
            case (req.operation)
              OP_ADD: begin
                if (count_full) begin
                  ovf_reg <= 1'b1;
                  state   <= S_FIN;
                end else begin
                  ovf_reg <= 1'b0;
                  divisor <= count_reg + 1'b1;
                  work    <= {{COUNT_BITS{1'b0}}, delta_mag};
                  step    <= STEP_W'(VALUE_BITS);
                  state   <= S_DIV;
                end
              end
              OP_MERGE: begin
                if (req.part_count == '0) begin
                  ovf_reg <= 1'b0;
                  state   <= S_FIN;
                end else if (count_sum[COUNT_BITS]) begin
                  ovf_reg <= 1'b1;
                  state   <= S_FIN;
                end else if (count_reg == '0) begin
                  ovf_reg   <= 1'b0;
                  mean_reg  <= req.value;
                  count_reg <= req.part_count;
                  state     <= S_FIN;
                end else begin
                  ovf_reg <= 1'b0;
                  divisor <= count_sum[COUNT_BITS-1:0];
                  work    <= {{(VALUE_BITS+1){1'b0}}, req.part_count};
                  step    <= STEP_W'(COUNT_BITS - 1);
                  state   <= S_MUL;
                end
              end
              OP_CLEAR: begin
                ovf_reg   <= 1'b0;
                mean_reg  <= '0;
                count_reg <= '0;
                state     <= S_FIN;
              end
              default: begin
                ovf_reg <= 1'b0;
                state   <= S_FIN;
              end
            endcase
          end
        end
        S_MUL: begin
          work <= work_mul;
          if (step == '0) begin
            step  <= STEP_W'(VALUE_BITS);
            state <= S_DIV;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DIV: begin
          work <= work_div;
          if (step == '0) begin
            state <= S_UPD;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_UPD: begin
          mean_reg  <= mean_next;
          count_reg <= divisor;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_mean  <= mean_reg;
            out_count <= count_reg;
            out_ovf   <= ovf_reg;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request closes the input until its result is produced
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input still open after a request was taken");

  // Division remainder stays below the divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> work[PROD_BITS-1:VALUE_BITS+1] < divisor)
    else $error("divider remainder not below divisor");

  // A dropped request can only happen with a nonempty aggregate
  a_ovf_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> out_count != '0)
    else $error("overflow flagged with empty count");

  // Divisor is never zero while dividing
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> divisor != '0)
    else $error("division by zero count");

endmodule

FILE: tb/sv/tb_running_mean_merge_top.sv
module tb_running_mean_merge_top
  import rmm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 32;
  localparam int CB = 32;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 1725;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  // Code 3 is not defined in the package; the block treats it as a no-op
  localparam rmm_op_t OP_NOP = 2'd3;

  typedef logic signed [VB-1:0] mean_t;
  typedef logic [CB-1:0] cnt_t;

  typedef struct packed {
    mean_t mean;
    cnt_t  count;
    logic  ovf;
  } stat_t;

  typedef struct packed {
    rmm_op_t op;
    mean_t   value;
    cnt_t    part_count;
    logic    typed;
    mean_t   mean;
    cnt_t    count;
    logic    ovf;
  } dir_row_t;

  logic clk;
  logic rst;
  logic quiet;
  int   errors;
  int   idle_cycles;
  int   stall_left;

  // Running aggregate as the block should hold it
  mean_t run_mean;
  cnt_t  run_count;

  stat_t pending_stats[$];

  rmm_in_if  #(.VALUE_BITS(VB), .COUNT_BITS(CB)) req_ch ();
  rmm_out_if #(.VALUE_BITS(VB), .COUNT_BITS(CB)) rsp_ch ();

  running_mean_merge_top #(.VALUE_BITS(VB), .COUNT_BITS(CB)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Directed requests: extremes, every operation, overflow and empty cases
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{OP_ADD,   32'h7FFFFFFF, 32'h00000000, 1'b1, 32'h7FFFFFFF, 32'h00000001, 1'b0},
    '{OP_ADD,   32'h80000000, 32'hFFFFFFFF, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_MERGE, 32'h12345678, 32'h00000000, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_MERGE, 32'h80000000, 32'h00000001, 1'b1, 32'h80000000, 32'h00000001, 1'b0},
    '{OP_MERGE, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h80000000, 32'h00000001, 1'b1},
    '{OP_MERGE, 32'h7FFFFFFF, 32'hFFFFFFFE, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_ADD,   32'h00000000, 32'h00000000, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_MERGE, 32'h00000000, 32'h00000001, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_NOP,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_CLEAR, 32'h00000000, 32'h00000000, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_NOP,   32'h5A5A5A5A, 32'hA5A5A5A5, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_ADD,   32'h00010000, 32'h00000000, 1'b1, 32'h00010000, 32'h00000001, 1'b0},
    '{OP_ADD,   32'hFFFF0000, 32'h00000000, 1'b1, 32'h00000000, 32'h00000002, 1'b0},
    '{OP_MERGE, 32'h00030000, 32'h00000002, 1'b1, 32'h00018000, 32'h00000004, 1'b0},
    '{OP_MERGE, 32'h80000000, 32'hFFFFFFFB, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_ADD,   32'h7FFFFFFF, 32'h00000000, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_CLEAR, 32'h00000000, 32'h00000000, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_MERGE, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0},
    '{OP_ADD,   32'h80000000, 32'h00000000, 1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1},
    '{OP_CLEAR, 32'h00000000, 32'h00000000, 1'b1, 32'h0,        32'h0,        1'b0},
    '{OP_ADD,   32'h00000001, 32'h00000000, 1'b1, 32'h00000001, 32'h00000001, 1'b0},
    '{OP_ADD,   32'h00000000, 32'h00000000, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_ADD,   32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0,        32'h0,        1'b0},
    '{OP_MERGE, 32'h80000000, 32'h00000007, 1'b0, 32'h0,        32'h0,        1'b0}
  };

  // m + trunc(k * (v - m) / n), truncating toward zero
  function automatic mean_t shift_mean(mean_t m, mean_t v, cnt_t k, logic [CB:0] n);
    logic [VB+1:0] diff;
    logic [VB+1:0] absd;
    logic [127:0]  prod;
    logic [127:0]  quo;
    diff = {{2{v[VB-1]}}, v} - {{2{m[VB-1]}}, m};
    absd = diff[VB+1] ? -diff : diff;
    prod = 128'(absd) * 128'(k);
    quo  = prod / 128'(n);
    return diff[VB+1] ? m - mean_t'(quo) : m + mean_t'(quo);
  endfunction

  // Apply one request to the running aggregate; returns the result it yields
  function automatic stat_t fold_request(rmm_op_t op, mean_t v, cnt_t k);
    logic [CB:0] sum;
    stat_t       res;
    res.ovf = 1'b0;
    case (op)
      OP_ADD: begin
        if (run_count == '1) begin
          res.ovf = 1'b1;
        end else begin
          run_mean  = shift_mean(run_mean, v, cnt_t'(1), {1'b0, run_count} + 1'b1);
          run_count = run_count + 1'b1;
        end
      end
      OP_MERGE: begin
        sum = {1'b0, run_count} + {1'b0, k};
        if (k != '0) begin
          if (sum[CB]) begin
            res.ovf = 1'b1;
          end else begin
            if (run_count == '0) run_mean = v;
            else run_mean = shift_mean(run_mean, v, k, sum);
            run_count = sum[CB-1:0];
          end
        end
      end
      OP_CLEAR: begin
        run_mean  = '0;
        run_count = '0;
      end
      default: ;
    endcase
    res.mean  = run_mean;
    res.count = run_count;
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic mean_t pick_value();
    int    r;
    mean_t v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: v = 32'h7FFFFFFF;
        1: v = 32'h80000000;
        2: v = '0;
        3: v = '1;
        default: v = 32'h1;
      endcase
    end else if (r < 50) begin
      // within about +/-10.0 in Q16.16
      v = $urandom_range(0, 32'h000A0000);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Partial counts: small mostly, plus exact fill and one-past-fill of the count
  function automatic cnt_t pick_part_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 60) return $urandom_range(1, 16);
    if (r < 75) return $urandom_range(1, 100000);
    if (r < 83) return $urandom;
    if (r < 92) return (run_count == '1) ? cnt_t'(1) : '1 - run_count;
    return (run_count == '0) ? '1 : '1 - run_count + 1'b1;
  endfunction

  // Present one request, wait for acceptance, record what it should yield
  task automatic push_req(rmm_op_t op, mean_t v, cnt_t k, logic typed, stat_t typed_res);
    stat_t pred;
    int    gap;
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.value      <= v;
    req_ch.part_count <= k;
    do @(posedge clk); while (!req_ch.ready);
    pred = fold_request(op, v, k);
    pending_stats.push_back(typed ? typed_res : pred);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    stat_t want;
    if (pending_stats.size() == 0) begin
      errors++;
      $display("%0t: unexpected result mean %h count %h overflowed %b", $time,
               rsp_ch.mean_out, rsp_ch.count_out, rsp_ch.overflowed);
    end else begin
      want = pending_stats.pop_front();
      if (rsp_ch.mean_out !== want.mean) begin
        errors++;
        $display("%0t: mean_out expected %h got %h", $time, want.mean, rsp_ch.mean_out);
      end
      if (rsp_ch.count_out !== want.count) begin
        errors++;
        $display("%0t: count_out expected %h got %h", $time, want.count, rsp_ch.count_out);
      end
      if (rsp_ch.overflowed !== want.ovf) begin
        errors++;
        $display("%0t: overflowed expected %b got %b", $time, want.ovf, rsp_ch.overflowed);
      end
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Alternate between stretches with idling and stretches without
  initial begin
    quiet <= 1'b0;
    forever begin
      repeat ($urandom_range(100, 600)) @(posedge clk);
      quiet <= ~quiet;
    end
  end

  // Result side: check, then stall at random
  initial begin
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Request side
  initial begin
    stat_t   typed_res;
    rmm_op_t op;
    mean_t   v;
    cnt_t    k;
    int      r;
    errors    = 0;
    run_mean  = '0;
    run_count = '0;
    rst       = 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_ADD;
    req_ch.value      <= '0;
    req_ch.part_count <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.mean  = directed_rows[i].mean;
      typed_res.count = directed_rows[i].count;
      typed_res.ovf   = directed_rows[i].ovf;
      push_req(directed_rows[i].op, directed_rows[i].value, directed_rows[i].part_count,
               directed_rows[i].typed, typed_res);
    end

    // Hold off until the block has returned everything
    wait_drained();

    // Random requests, checked against the predictor only
    typed_res = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_CLEAR;
      else if (r < 7) op = OP_NOP;
      else if (r < 37) op = OP_MERGE;
      else op = OP_ADD;
      v = pick_value();
      k = (op == OP_MERGE) ? pick_part_count() : cnt_t'($urandom);
      push_req(op, v, k, 1'b0, typed_res);
      if ($urandom_range(0, 199) == 0) wait_drained();
    end

    // Drain, then leave room for a stray late result
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
